FILE: sv/stable_quadratic_roots_macros.svh
// Assertion macros for the stable_quadratic_roots block.
// Expects clk_i and rst_ni in the scope of use.
`ifndef STABLE_QUADRATIC_ROOTS_MACROS_SVH
`define STABLE_QUADRATIC_ROOTS_MACROS_SVH

// Clocked property, disabled in reset.
`define SQR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define SQR_ASSERT_IMPL(lbl, ante, cons, msg) \
  `SQR_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define SQR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SQR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: sv/sqr_pkg.sv
// Package for the stable quadratic roots block: widths, status codes, stage types.
// No dependencies.
`timescale 1ns / 1ps
package sqr_pkg;
  localparam int DW     = 32;          // coefficient and root width
  localparam int FB     = 16;          // fraction bits
  localparam int PW     = 2 * DW;      // product width
  localparam int SQ_W   = DW + 1;      // square root width, one cell per bit
  localparam int DISC_W = 2 * SQ_W;    // discriminant width
  localparam int SR_W   = SQ_W + 3;    // square root remainder width
  localparam int NUM_W  = DW + 3;      // signed numerator / divisor width
  localparam int MAG_W  = DW + 2;      // magnitude width
  localparam int NQ     = MAG_W + FB;  // quotient bits, one cell per bit
  localparam int REM_W  = MAG_W + 1;   // divider remainder width
  localparam int NST    = 3 + SQ_W + NQ;  // pipeline stages

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_ZERO_DIV = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic                 neg_disc;
  } coef_t;

  typedef struct packed {
    logic [DISC_W-1:0] rad;
    logic [SR_W-1:0]   rem;
    logic [SQ_W-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic [NQ-1:0]    num;
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [NQ-1:0]    quo;
    logic             neg;
  } div_t;

  typedef struct packed {
    logic signed [DW-1:0] root_plus;
    logic signed [DW-1:0] root_minus;
    status_e              status;
  } root_t;
endpackage

FILE: sv/sqr_ifs.sv
// Stream interfaces for coefficient and root transfers.
// Depends on sqr_pkg.
`timescale 1ns / 1ps
interface sqr_coef_if;
  import sqr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] coef_a;
  logic signed [DW-1:0] coef_b;
  logic signed [DW-1:0] coef_c;
  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface sqr_root_if;
  import sqr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] root_plus;
  logic signed [DW-1:0] root_minus;
  logic [1:0]           status;
  modport source (output valid, output root_plus, output root_minus, output status, input ready);
  modport sink   (input valid, input root_plus, input root_minus, input status, output ready);
endinterface

FILE: sv/sqr_front.sv
// Front end: coefficient products (stage 0) and discriminant (stage 1).
// Depends on sqr_pkg.
`timescale 1ns / 1ps
module sqr_front (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [sqr_pkg::DW-1:0] a_i,
  input  logic signed [sqr_pkg::DW-1:0] b_i,
  input  logic signed [sqr_pkg::DW-1:0] c_i,
  output sqr_pkg::coef_t               coef_o,
  output sqr_pkg::sqrt_t               sqrt_o
);
  import sqr_pkg::*;

  logic [DW-1:0]     mag_a, mag_b, mag_c;
  logic [PW-1:0]     bb_q, ac_q;
  logic              sdiff_q;
  coef_t             coef1_q, coef_q;
  sqrt_t             sqrt_q;
  logic [DISC_W-1:0] ac4, bbx, disc;
  logic              neg;

  assign mag_a = a_i[DW-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DW-1] ? (~b_i + 1'b1) : b_i;
  assign mag_c = c_i[DW-1] ? (~c_i + 1'b1) : c_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q    <= mag_b * mag_b;
      ac_q    <= mag_a * mag_c;
      sdiff_q <= a_i[DW-1] ^ c_i[DW-1];
      coef1_q <= '{a: a_i, b: b_i, c: c_i, neg_disc: 1'b0};
    end
  end

  // -4ac adds when a and c differ in sign
  always_comb begin
    ac4 = {ac_q, 2'b00};
    bbx = {2'b00, bb_q};
    neg = 1'b0;
    if (sdiff_q) begin
      disc = bbx + ac4;
    end else begin
      neg  = ac4 > bbx;
      disc = bbx - ac4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef_q <= '{a: coef1_q.a, b: coef1_q.b, c: coef1_q.c, neg_disc: neg};
      sqrt_q <= '{rad: disc, rem: '0, root: '0};
    end
  end

  assign coef_o = coef_q;
  assign sqrt_o = sqrt_q;
endmodule

FILE: sv/sqr_sqrt_cell.sv
// One root bit of the digit-by-digit square root; radicand shifts two bits a cell.
// Depends on sqr_pkg.
`timescale 1ns / 1ps
module sqr_sqrt_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  sqr_pkg::coef_t coef_i,
  input  sqr_pkg::sqrt_t sqrt_i,
  output sqr_pkg::coef_t coef_o,
  output sqr_pkg::sqrt_t sqrt_o
);
  import sqr_pkg::*;

  coef_t           coef_q;
  sqrt_t           sqrt_q, sqrt_d;
  logic [SR_W-1:0] rem_sh, trial;
  logic            ge;

  always_comb begin
    rem_sh      = {sqrt_i.rem[SR_W-3:0], sqrt_i.rad[DISC_W-1:DISC_W-2]};
    trial       = {1'b0, sqrt_i.root, 2'b01};
    ge          = rem_sh >= trial;
    sqrt_d.rad  = {sqrt_i.rad[DISC_W-3:0], 2'b00};
    sqrt_d.rem  = ge ? (rem_sh - trial) : rem_sh;
    sqrt_d.root = {sqrt_i.root[SQ_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef_q <= coef_i;
      sqrt_q <= sqrt_d;
    end
  end

  assign coef_o = coef_q;
  assign sqrt_o = sqrt_q;
endmodule

FILE: sv/sqr_div_setup.sv
// Picks numerators and divisors for both roots, flags special cases.
// Depends on sqr_pkg.
`timescale 1ns / 1ps
module sqr_div_setup (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  sqr_pkg::coef_t        coef_i,
  input  logic [sqr_pkg::SQ_W-1:0] root_i,
  output sqr_pkg::status_e      pre_o,
  output sqr_pkg::div_t [1:0]   lane_o
);
  import sqr_pkg::*;

  logic signed [NUM_W-1:0] ax, bx, cx, dx, two_a, two_c;
  logic signed [NUM_W-1:0] num [2];
  logic signed [NUM_W-1:0] den [2];
  logic signed [NUM_W-1:0] nabs, dabs;
  logic                    bpos, bneg, zero;
  div_t [1:0]              lane_d, lane_q;
  status_e                 pre_d, pre_q;

  always_comb begin
    ax    = {{(NUM_W-DW){coef_i.a[DW-1]}}, coef_i.a};
    bx    = {{(NUM_W-DW){coef_i.b[DW-1]}}, coef_i.b};
    cx    = {{(NUM_W-DW){coef_i.c[DW-1]}}, coef_i.c};
    dx    = {{(NUM_W-SQ_W){1'b0}}, root_i};
    two_a = {ax[NUM_W-2:0], 1'b0};
    two_c = {cx[NUM_W-2:0], 1'b0};
    bpos  = !coef_i.b[DW-1] && (coef_i.b != '0);
    bneg  = coef_i.b[DW-1];
    num[0] = bpos ? -two_c : (dx - bx);
    den[0] = bpos ? (bx + dx) : two_a;
    num[1] = bneg ? -two_c : (-bx - dx);
    den[1] = bneg ? (bx - dx) : two_a;
    zero   = (den[0] == '0) || (den[1] == '0);
    for (int l = 0; l < 2; l++) begin
      nabs = num[l][NUM_W-1] ? -num[l] : num[l];
      dabs = den[l][NUM_W-1] ? -den[l] : den[l];
      lane_d[l].num = {nabs[MAG_W-1:0], {FB{1'b0}}};
      lane_d[l].rem = '0;
      lane_d[l].den = dabs[MAG_W-1:0];
      lane_d[l].quo = '0;
      lane_d[l].neg = num[l][NUM_W-1] ^ den[l][NUM_W-1];
    end
    if (coef_i.neg_disc) begin
      pre_d = ST_NEG_DISC;
    end else if (zero) begin
      pre_d = ST_ZERO_DIV;
    end else begin
      pre_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      pre_q  <= pre_d;
    end
  end

  assign lane_o = lane_q;
  assign pre_o  = pre_q;
endmodule

FILE: sv/sqr_div_cell.sv
// One quotient bit of both restoring dividers.
// Depends on sqr_pkg.
`timescale 1ns / 1ps
module sqr_div_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  sqr_pkg::status_e    pre_i,
  input  sqr_pkg::div_t [1:0] lane_i,
  output sqr_pkg::status_e    pre_o,
  output sqr_pkg::div_t [1:0] lane_o
);
  import sqr_pkg::*;

  div_t [1:0]       lane_d, lane_q;
  status_e          pre_q;
  logic [REM_W-1:0] rem_sh [2];
  logic             ge [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l]     = {lane_i[l].rem[MAG_W-1:0], lane_i[l].num[NQ-1]};
      ge[l]         = rem_sh[l] >= {1'b0, lane_i[l].den};
      lane_d[l].num = {lane_i[l].num[NQ-2:0], 1'b0};
      lane_d[l].rem = ge[l] ? (rem_sh[l] - {1'b0, lane_i[l].den}) : rem_sh[l];
      lane_d[l].den = lane_i[l].den;
      lane_d[l].quo = {lane_i[l].quo[NQ-2:0], ge[l]};
      lane_d[l].neg = lane_i[l].neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      pre_q  <= pre_i;
    end
  end

  assign lane_o = lane_q;
  assign pre_o  = pre_q;
endmodule

FILE: sv/sqr_back.sv
// Saturation, sign and status of the finished quotients.
// Depends on sqr_pkg.
`timescale 1ns / 1ps
module sqr_back (
  input  sqr_pkg::status_e    pre_i,
  input  sqr_pkg::div_t [1:0] lane_i,
  output sqr_pkg::root_t      res_o
);
  import sqr_pkg::*;

  localparam logic [NQ-1:0] HALF = NQ'(1) << (DW - 1);

  logic [NQ-1:0] lim [2];
  logic [NQ-1:0] qm  [2];
  logic [DW-1:0] val [2];
  logic          sat [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lim[l] = lane_i[l].neg ? HALF : (HALF - 1'b1);
      sat[l] = lane_i[l].quo > lim[l];
      qm[l]  = sat[l] ? lim[l] : lane_i[l].quo;
      val[l] = lane_i[l].neg ? (~qm[l][DW-1:0] + 1'b1) : qm[l][DW-1:0];
    end
    if (pre_i != ST_OK) begin
      res_o.root_plus  = '0;
      res_o.root_minus = '0;
      res_o.status     = pre_i;
    end else begin
      res_o.root_plus  = val[0];
      res_o.root_minus = val[1];
      res_o.status     = (sat[0] || sat[1]) ? ST_SAT : ST_OK;
    end
  end
endmodule

FILE: sv/stable_quadratic_roots.sv
// Top level of the stable quadratic roots block: pipeline of cells and output buffer.
// Depends on sqr_pkg, sqr_ifs, the sqr_* cell modules and the macros header.
//
// Usage:
//   coef_i carries a, b, c (signed Q16.16); root_o returns root_plus, root_minus
//   and status (0 ok, 1 negative discriminant, 2 zero divisor, 3 saturated).
//   A transfer happens when valid and ready are both high at a clock edge.
// Throughput: one coefficient set per cycle while the skid register is empty.
// Stages from input transfer to output valid:
//   2 front stages (products, discriminant), 33 square root cells (one root
//   bit each), 1 divisor setup stage, 50 divider cells (one quotient bit each,
//   both roots side by side), then the output register.
// The pipeline advances as a whole; a two-entry output buffer (output
//   register plus skid register) sits at the end. While the receiver stalls,
//   input is still taken until the skid register fills; ready is registered
//   and has no path from root_o.ready.
// Reset (rst_ni low, asynchronous) clears the stage valid bits and the buffer
//   valid flags; no result is shown until a new set has passed through.
`timescale 1ns / 1ps
`include "stable_quadratic_roots_macros.svh"
module stable_quadratic_roots (
  input  logic              clk_i,
  input  logic              rst_ni,
  sqr_coef_if.sink          coef_i,
  sqr_root_if.source        root_o
);
  import sqr_pkg::*;

  // one valid bit per pipeline stage
  logic [NST-1:0] valid_q;
  logic           adv;

  // output buffer
  logic  ov_q, sv_q;
  root_t out_q, skid_q, res;
  logic  push, pop;

  coef_t      cf_s [SQ_W+1];
  sqrt_t      sq_s [SQ_W+1];
  div_t [1:0] dv_s [NQ+1];
  status_e    pre_s [NQ+1];

  // whole pipe moves unless the skid register holds a result
  assign adv          = !sv_q;
  assign coef_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NST-2:0], coef_i.valid};
    end
  end

  sqr_front u_front (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (coef_i.coef_a),
    .b_i    (coef_i.coef_b),
    .c_i    (coef_i.coef_c),
    .coef_o (cf_s[0]),
    .sqrt_o (sq_s[0])
  );

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    sqr_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .coef_i (cf_s[k]),
      .sqrt_i (sq_s[k]),
      .coef_o (cf_s[k+1]),
      .sqrt_o (sq_s[k+1])
    );
  end

  sqr_div_setup u_setup (
    .clk_i  (clk_i),
    .en_i   (adv),
    .coef_i (cf_s[SQ_W]),
    .root_i (sq_s[SQ_W].root),
    .pre_o  (pre_s[0]),
    .lane_o (dv_s[0])
  );

  for (genvar k = 0; k < NQ; k++) begin : g_div
    sqr_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .pre_i  (pre_s[k]),
      .lane_i (dv_s[k]),
      .pre_o  (pre_s[k+1]),
      .lane_o (dv_s[k+1])
    );
  end

  sqr_back u_back (
    .pre_i  (pre_s[NQ]),
    .lane_i (dv_s[NQ]),
    .res_o  (res)
  );

  // push only happens with the skid register empty
  assign push = adv && valid_q[NST-1];
  assign pop  = ov_q && root_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (pop || !ov_q) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= push;
      end
    end else if (push) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !ov_q) begin
      out_q <= sv_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign root_o.valid      = ov_q;
  assign root_o.root_plus  = out_q.root_plus;
  assign root_o.root_minus = out_q.root_minus;
  assign root_o.status     = out_q.status;

  `SQR_ASSERT_IMPL(a_skid_needs_out, sv_q, ov_q, "skid full while output empty")
  `SQR_ASSERT_NEXT(a_push_shows, push && !ov_q, ov_q, "pushed result not shown")
  `SQR_ASSERT_IMPL(a_neg_disc_zero, ov_q && (out_q.status == ST_NEG_DISC), (out_q.root_plus == '0) && (out_q.root_minus == '0), "nonzero roots with negative discriminant")
endmodule

FILE: dv/tb_stable_quadratic_roots.sv
// Testbench for stable_quadratic_roots: directed table plus random coefficient sets,
// with a self-contained predictor and an in-order scoreboard. Depends on sqr_pkg and sqr_ifs.
`timescale 1ns / 1ps
module tb_stable_quadratic_roots;
  import sqr_pkg::*;

  localparam int LATENCY = 86;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  sqr_coef_if coef_if ();
  sqr_root_if root_if ();

  stable_quadratic_roots dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_if.sink),
    .root_o (root_if.source)
  );

  // expected root sets, oldest first
  root_t roots_due[$];
  int    n_fail = 0;
  int    n_sent = 0;
  int    n_seen = 0;
  int    st_count[4] = '{0, 0, 0, 0};

  // One directed row: coefficients, and optionally a typed-in answer.
  typedef struct {
    logic signed [31:0] a, b, c;
    bit                 fixed;
    root_t              ans;
  } coef_row_t;

  // floor square root of a 128-bit value (result below 2^64)
  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= v) r = t;
    end
    return r;
  endfunction

  // num * 2^FB / den, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] scaled_quot(input logic signed [127:0] num,
                                              input logic signed [127:0] den,
                                              inout bit sat);
    logic [127:0] nm, dm, q, lim;
    bit           neg;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q = (nm << FB) / dm;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic root_t predict_roots(input logic signed [31:0] a_in,
                                          input logic signed [31:0] b_in,
                                          input logic signed [31:0] c_in);
    logic signed [127:0] a, b, c, disc, d, nump, denp, numm, denm;
    root_t r;
    bit    sat;
    a = a_in; b = b_in; c = c_in;
    sat = 1'b0;
    r = '{root_plus: '0, root_minus: '0, status: ST_OK};
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.status = ST_NEG_DISC;
      return r;
    end
    d = isqrt128(disc);
    if (b > 0) begin nump = -2 * c; denp = b + d; end
    else begin nump = d - b; denp = 2 * a; end
    if (b < 0) begin numm = -2 * c; denm = b - d; end
    else begin numm = -b - d; denm = 2 * a; end
    if (denp == 0 || denm == 0) begin
      r.status = ST_ZERO_DIV;
      return r;
    end
    r.root_plus  = scaled_quot(nump, denp, sat);
    r.root_minus = scaled_quot(numm, denm, sat);
    r.status     = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Directed rows. Typed answers only where obvious.
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MN  = 32'sh8000_0000;
  localparam root_t R_NEG  = '{root_plus: '0, root_minus: '0, status: ST_NEG_DISC};
  localparam root_t R_ZDIV = '{root_plus: '0, root_minus: '0, status: ST_ZERO_DIV};
  coef_row_t coef_table[] = '{
    '{0, 0, 0, 1, R_ZDIV},                      // all zero: linear, zero divisor
    '{ONE, 0, ONE, 1, R_NEG},                   // x^2+1: no real roots
    '{MX, 0, MX, 1, R_NEG},                     // extremes, negative discriminant
    '{MN, 0, MN, 1, R_NEG},
    '{0, ONE, ONE, 1, R_ZDIV},                  // linear, b > 0
    '{0, -ONE, ONE, 1, R_ZDIV},                 // linear, b < 0
    '{0, MN, MX, 1, R_ZDIV},
    '{ONE, 0, -ONE, 0, R_NEG},                  // x^2-1: roots +-1
    '{ONE, -3 * ONE, 2 * ONE, 0, R_NEG},        // b < 0
    '{ONE, 3 * ONE, 2 * ONE, 0, R_NEG},         // b > 0
    '{ONE, 2 * ONE, ONE, 0, R_NEG},             // double root
    '{1, MX, 1, 0, R_NEG},                      // tiny a: root saturates
    '{1, MN, 1, 0, R_NEG},
    '{MX, MX, MN, 0, R_NEG},
    '{MN, MN, MX, 0, R_NEG},
    '{MN, MX, MX, 0, R_NEG},
    '{MX, MN, 0, 0, R_NEG},                     // c = 0
    '{1, 0, 0, 0, R_NEG},
    '{-1, -1, -1, 0, R_NEG},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 0, R_NEG}
  };

  // sink stall counter set each transfer
  int  rx_wait;
  bit  sender_done = 1'b0;

  // valid stays high into the next set when there is no gap
  task automatic send_coefs(input logic signed [31:0] a, input logic signed [31:0] b,
                            input logic signed [31:0] c, input bit fixed, input root_t ans);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      coef_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    coef_if.valid  <= 1'b1;
    coef_if.coef_a <= a;
    coef_if.coef_b <= b;
    coef_if.coef_c <= c;
    do @(posedge clk_i); while (!coef_if.ready);
    roots_due.push_back(fixed ? ans : predict_roots(a, b, c));
    n_sent++;
    @(negedge clk_i);
  endtask

  // random coefficient of mixed magnitude
  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
      2: return ($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      3: return ($urandom_range(0, 1) ? MX : MN);
      4: return 0;
      default: return ($signed($urandom_range(0, 20)) - 10) * ONE;
    endcase
  endfunction

  // Stimulus
  initial begin
    logic signed [31:0] a, b, c, x1, x2;
    coef_if.valid  = 1'b0;
    coef_if.coef_a = '0;
    coef_if.coef_b = '0;
    coef_if.coef_c = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (coef_table[i])
      send_coefs(coef_table[i].a, coef_table[i].b, coef_table[i].c,
                 coef_table[i].fixed, coef_table[i].ans);
    for (int i = 0; i < 500; i++) begin
      if (i == 250) begin
        // drain the pipe once before carrying on
        coef_if.valid <= 1'b0;
        while (roots_due.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 2) != 0) begin
        // built from real roots, mostly well-posed sets
        x1 = ($signed($urandom_range(0, 400)) - 200) * 32'sh4000;
        x2 = ($signed($urandom_range(0, 400)) - 200) * 32'sh4000;
        a = $signed($urandom_range(1, 4)) * ONE * ($urandom_range(0, 1) ? 1 : -1);
        b = -(a >>> 16) * (x1 + x2);
        c = 32'((a >>> 16) * ((64'(x1) * 64'(x2)) >>> 16));
      end else begin
        a = rand_coef();
        b = rand_coef();
        c = rand_coef();
      end
      send_coefs(a, b, c, 1'b0, R_NEG);
    end
    coef_if.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stalls, compare against oldest expectation
  initial begin
    root_t want;
    root_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (rx_wait > 0) begin
        root_if.ready <= 1'b0;
        repeat (rx_wait) @(negedge clk_i);
      end
      root_if.ready <= 1'b1;
      do @(posedge clk_i); while (!root_if.valid);
      n_seen++;
      if (roots_due.size() == 0) begin
        $display("%0t: unexpected result plus=%h minus=%h status=%0d", $time,
                 root_if.root_plus, root_if.root_minus, root_if.status);
        n_fail++;
      end else begin
        want = roots_due.pop_front();
        st_count[want.status]++;
        if (root_if.root_plus !== want.root_plus) begin
          $display("%0t: root_plus expected %h actual %h", $time, want.root_plus,
                   root_if.root_plus);
          n_fail++;
        end
        if (root_if.root_minus !== want.root_minus) begin
          $display("%0t: root_minus expected %h actual %h", $time, want.root_minus,
                   root_if.root_minus);
          n_fail++;
        end
        if (root_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   root_if.status);
          n_fail++;
        end
      end
    end
  end

  // End of run
  initial begin
    wait (sender_done);
    while (roots_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Sent %0d coefficient sets, checked %0d results", n_sent, n_seen);
    $display("Status mix: ok %0d, neg disc %0d, zero div %0d, saturated %0d",
             st_count[0], st_count[1], st_count[2], st_count[3]);
    if (n_fail == 0) begin
      $display("PASS stable_quadratic_roots");
    end else begin
      $display("FAIL stable_quadratic_roots");
    end
    $finish;
  end

  // Watchdog: a time limit well beyond what 520 items with the widest gaps and stalls take
  initial begin
    #5ms;
    $display("FAIL stable_quadratic_roots");
    $finish;
  end
endmodule
